FILE: rtl/core/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg: seven-segment glyph generator package
// Character codes, segment masks, font geometry and the segment shape tests.
// ----------------------------------------------------------------------------
package ssg_pkg;

    // Character codes the generator knows
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Register index bit of paddr (byte address 4*i)
    localparam logic REG_FONT_SEL = 1'b0;

    // Font select codes
    localparam logic FONT_LARGE = 1'b0;

    // Lit alpha value
    localparam logic [7:0] ALPHA_ON = 8'hFF;

    // Signed width for coordinate differences
    localparam int CW = 9;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        logic [6:0] w;        // digit box width
        logic [6:0] h;        // box height
        logic [6:0] t;        // stroke thickness
        logic [6:0] mx;       // horizontal margin
        logic [6:0] top;      // top bar row
        logic [6:0] mid;      // middle bar row
        logic [6:0] bot;      // bottom bar row
        logic [6:0] up;       // upper vertical bar row
        logic [6:0] low;      // lower vertical bar row
        logic [6:0] vh;       // vertical bar height
        logic [6:0] rx;       // right bar column
        logic [6:0] iw;       // horizontal bar length, w - 2*mx
        logic [6:0] dig_adv;
        logic [6:0] col_w;
        logic [6:0] col_adv;
        logic [6:0] dot_x;
        logic [6:0] dot_top;
        logic [6:0] dot_bot;
        logic [6:0] dash_w;
        logic [6:0] dash_adv;
        logic [6:0] dash_y;   // (h - t) / 2
    } t_geom;

    // Geometry for each font size
    function automatic t_geom geom(input logic sel);
        t_geom g;
        if (sel == FONT_LARGE) begin
            g = '{w: 7'd76, h: 7'd124, t: 7'd13, mx: 7'd6, top: 7'd2, mid: 7'd55,
                  bot: 7'd109, up: 7'd13, low: 7'd66, vh: 7'd40, rx: 7'd63,
                  iw: 7'd64, dig_adv: 7'd82, col_w: 7'd26, col_adv: 7'd30,
                  dot_x: 7'd6, dot_top: 7'd38, dot_bot: 7'd74, dash_w: 7'd48,
                  dash_adv: 7'd56, dash_y: 7'd55};
        end else begin
            g = '{w: 7'd34, h: 7'd56, t: 7'd6, mx: 7'd3, top: 7'd1, mid: 7'd25,
                  bot: 7'd49, up: 7'd6, low: 7'd30, vh: 7'd18, rx: 7'd28,
                  iw: 7'd28, dig_adv: 7'd38, col_w: 7'd14, col_adv: 7'd18,
                  dot_x: 7'd4, dot_top: 7'd16, dot_bot: 7'd34, dash_w: 7'd22,
                  dash_adv: 7'd28, dash_y: 7'd25};
        end
        return g;
    endfunction

    // Segment mask, gfedcba, for a decimal digit
    function automatic logic [6:0] seg_mask(input logic [3:0] d);
        logic [6:0] m;
        unique case (d)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            4'd9:    m = 7'h6F;
            default: m = 7'h00;
        endcase
        return m;
    endfunction

    function automatic t_coord to_coord(input logic [6:0] v);
        return t_coord'({2'b00, v});
    endfunction

    // Hexagonal horizontal bar: row r keeps columns ins..len-1-ins
    function automatic logic on_hbar(input logic [6:0] px, input logic [6:0] py,
                                     input logic [6:0] x, input logic [6:0] y,
                                     input logic [6:0] len, input logic [6:0] th);
        t_coord r;
        t_coord c;
        t_coord ins;
        r   = to_coord(py) - to_coord(y);
        c   = to_coord(px) - to_coord(x);
        ins = to_coord(th >> 1) - r;
        if (ins < 0) begin
            ins = -ins;
        end
        return (r >= 0) && (r < to_coord(th)) && (c >= ins) &&
               (c <= to_coord(len) - ins - t_coord'(1));
    endfunction

    // Vertical bar tapered at top and bottom
    function automatic logic on_vbar(input logic [6:0] px, input logic [6:0] py,
                                     input logic [6:0] x, input logic [6:0] y,
                                     input logic [6:0] th, input logic [6:0] len);
        t_coord r;
        t_coord c;
        t_coord half;
        t_coord tail;
        t_coord ins;
        r    = to_coord(py) - to_coord(y);
        c    = to_coord(px) - to_coord(x);
        half = to_coord(th >> 1);
        tail = to_coord(len) - half;
        if (r >= tail) begin
            ins = r - tail + t_coord'(1);
        end else begin
            ins = half - r;
            if (ins < 0) begin
                ins = '0;
            end
        end
        return (r >= 0) && (r < to_coord(len)) && (c >= ins) &&
               (c < to_coord(th) - ins);
    endfunction

endpackage

FILE: rtl/core/seven_segment_glyph_pixel_generator.sv
// ----------------------------------------------------------------------------
// seven_segment_glyph_pixel_generator: per-pixel seven-segment glyph renderer
// Pipeline: an input transfer passes through the input reg and then the
// result reg before its result transfer.
// Throughput: one pixel per cycle unless stalled; parallel segment comparators.
// Stalls: o_stall rises only while both registers hold data and i_stall is high.
// Reset: clears both pipeline valids and selects the large font.
// ----------------------------------------------------------------------------
module seven_segment_glyph_pixel_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_glyph_code,
    input  logic [6:0]  i_pixel_x,
    input  logic [6:0]  i_pixel_y,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_glyph_known,
    output logic [7:0]  o_pixel_alpha,
    output logic [6:0]  o_advance_width,
    output logic [6:0]  o_box_width,
    output logic [6:0]  o_box_height,
    output logic        o_inside_box,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_font_sel;
    logic        r_s1_valid;
    logic [7:0]  r_s1_code;
    logic [6:0]  r_s1_px;
    logic [6:0]  r_s1_py;
    logic        r_out_valid;
    logic        r_known;
    logic [7:0]  r_alpha;
    logic [6:0]  r_adv;
    logic [6:0]  r_bw;
    logic [6:0]  r_bh;
    logic        r_inside;

    logic        s1_take;
    logic        s2_take;

    ssg_pkg::t_geom g;
    logic        n_known;
    logic [6:0]  n_adv;
    logic [6:0]  n_bw;
    logic [6:0]  n_bh;
    logic        n_inside;
    logic [7:0]  n_alpha;
    logic [6:0]  mask;
    logic        is_digit;
    logic        lit_digit;
    logic        lit_dash;
    logic        lit_colon;
    logic        dot_cx;
    logic        dot_cy;
    logic        lit;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ssg_pkg::REG_FONT_SEL) ? {31'd0, r_font_sel} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_sel <= ssg_pkg::FONT_LARGE;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == ssg_pkg::REG_FONT_SEL) begin
            r_font_sel <= pwdata[0];
        end
    end

    // Pipeline flow control
    assign s2_take = !r_out_valid || !i_stall;
    assign s1_take = !r_s1_valid || s2_take;
    assign o_stall = !s1_take;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_take) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_valid) begin
            r_s1_code <= i_glyph_code;
            r_s1_px   <= i_pixel_x;
            r_s1_py   <= i_pixel_y;
        end
    end

    // Glyph class and box size
    assign g        = ssg_pkg::geom(r_font_sel);
    assign is_digit = (r_s1_code >= ssg_pkg::CHAR_ZERO) && (r_s1_code <= ssg_pkg::CHAR_NINE);

    always_comb begin
        n_known = 1'b1;
        n_adv   = '0;
        n_bw    = '0;
        n_bh    = '0;
        priority if (r_s1_code == ssg_pkg::CHAR_SPACE) begin
            n_adv = g.dig_adv;
        end else if (r_s1_code == ssg_pkg::CHAR_DASH) begin
            n_adv = g.dash_adv;
            n_bw  = g.dash_w;
            n_bh  = g.h;
        end else if (r_s1_code == ssg_pkg::CHAR_COLON) begin
            n_adv = g.col_adv;
            n_bw  = g.col_w;
            n_bh  = g.h;
        end else if (is_digit) begin
            n_adv = g.dig_adv;
            n_bw  = g.w;
            n_bh  = g.h;
        end else begin
            n_known = 1'b0;
        end
    end

    assign n_inside = (r_s1_px < n_bw) && (r_s1_py < n_bh);

    // Segment shape tests
    assign mask = ssg_pkg::seg_mask(r_s1_code[3:0]);

    assign lit_digit =
        (mask[0] && ssg_pkg::on_hbar(r_s1_px, r_s1_py, g.mx, g.top, g.iw, g.t)) ||
        (mask[1] && ssg_pkg::on_vbar(r_s1_px, r_s1_py, g.rx, g.up, g.t, g.vh)) ||
        (mask[2] && ssg_pkg::on_vbar(r_s1_px, r_s1_py, g.rx, g.low, g.t, g.vh)) ||
        (mask[3] && ssg_pkg::on_hbar(r_s1_px, r_s1_py, g.mx, g.bot, g.iw, g.t)) ||
        (mask[4] && ssg_pkg::on_vbar(r_s1_px, r_s1_py, 7'd0, g.low, g.t, g.vh)) ||
        (mask[5] && ssg_pkg::on_vbar(r_s1_px, r_s1_py, 7'd0, g.up, g.t, g.vh)) ||
        (mask[6] && ssg_pkg::on_hbar(r_s1_px, r_s1_py, g.mx, g.mid, g.iw, g.t));

    assign lit_dash = ssg_pkg::on_hbar(r_s1_px, r_s1_py, 7'd0, g.dash_y, g.dash_w, g.t);

    assign dot_cx = (r_s1_px >= g.dot_x) && ({1'b0, r_s1_px} < {1'b0, g.dot_x} + {1'b0, g.t});
    assign dot_cy = ((r_s1_py >= g.dot_top) &&
                     ({1'b0, r_s1_py} < {1'b0, g.dot_top} + {1'b0, g.t})) ||
                    ((r_s1_py >= g.dot_bot) &&
                     ({1'b0, r_s1_py} < {1'b0, g.dot_bot} + {1'b0, g.t}));
    assign lit_colon = dot_cx && dot_cy;

    always_comb begin
        lit = 1'b0;
        if (n_inside) begin
            priority if (r_s1_code == ssg_pkg::CHAR_DASH) begin
                lit = lit_dash;
            end else if (r_s1_code == ssg_pkg::CHAR_COLON) begin
                lit = lit_colon;
            end else begin
                lit = lit_digit;
            end
        end
    end

    assign n_alpha = lit ? ssg_pkg::ALPHA_ON : 8'd0;

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_take) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_take && r_s1_valid) begin
            r_known  <= n_known;
            r_alpha  <= n_alpha;
            r_adv    <= n_adv;
            r_bw     <= n_bw;
            r_bh     <= n_bh;
            r_inside <= n_inside;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_glyph_known   = r_known;
    assign o_pixel_alpha   = r_alpha;
    assign o_advance_width = r_adv;
    assign o_box_width     = r_bw;
    assign o_box_height    = r_bh;
    assign o_inside_box    = r_inside;

    // Checks
    a_alpha_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_alpha == 8'd0 || o_inside_box))
        else $error("lit pixel outside glyph box");

    a_inside_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_box) |-> (o_glyph_known && o_box_width != 7'd0))
        else $error("inside box for unknown or empty glyph");

    a_unknown_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_glyph_known) |-> (o_advance_width == 7'd0 && o_box_height == 7'd0))
        else $error("unknown glyph reports a size");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled while pipeline has room");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: seven-segment glyph pixel generator
// Streams character/pixel transfers through the block under random idling and
// stalls, switches the font size over the APB port between phases, and checks
// every result field against a pixel predictor kept in the bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [2:0] ADDR_FONT_SEL = {ssg_pkg::REG_FONT_SEL, 2'b00};
    localparam logic [2:0] ADDR_SPARE    = {~ssg_pkg::REG_FONT_SEL, 2'b00};
    localparam int         IDLE_PCT      = 16;
    localparam int         SETTLE_CYCLES = 4;

    typedef struct {
        logic [7:0] code;
        logic [6:0] x;
        logic [6:0] y;
    } t_pixel_req;

    typedef struct packed {
        logic       known;
        logic [7:0] alpha;
        logic [6:0] adv;
        logic [6:0] bw;
        logic [6:0] bh;
        logic       in_box;
    } t_pixel_res;

    typedef struct {
        int w, h, t, mx, top, mid, bot, up, low, vh, rx, dig_adv;
        int col_w, col_adv, dot_x, dot_top, dot_bot, dash_w, dash_adv;
    } t_font_geom;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_glyph_code = '0;
    logic [6:0]  i_pixel_x = '0;
    logic [6:0]  i_pixel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_glyph_known;
    logic [7:0]  o_pixel_alpha;
    logic [6:0]  o_advance_width;
    logic [6:0]  o_box_width;
    logic [6:0]  o_box_height;
    logic        o_inside_box;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    t_pixel_req pixel_requests_q[$];
    t_pixel_res pixel_results_q[$];
    logic       font_sel = ssg_pkg::FONT_LARGE;
    logic       req_taken = 1'b0;
    bit         hold_sender = 1'b0;
    int         idle_pct = IDLE_PCT;
    int         mismatch_count = 0;
    int         pixels_checked = 0;
    int         pixels_lit = 0;
    int         unknown_seen = 0;

    seven_segment_glyph_pixel_generator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_glyph_code(i_glyph_code), .i_pixel_x(i_pixel_x), .i_pixel_y(i_pixel_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_glyph_known(o_glyph_known), .o_pixel_alpha(o_pixel_alpha),
        .o_advance_width(o_advance_width), .o_box_width(o_box_width),
        .o_box_height(o_box_height), .o_inside_box(o_inside_box),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Font dimensions for the large and the compact size
    function automatic t_font_geom font_geometry(input logic sel);
        t_font_geom g;
        if (sel == ssg_pkg::FONT_LARGE) begin
            g = '{76, 124, 13, 6, 2, 55, 109, 13, 66, 40, 63, 82,
                  26, 30, 6, 38, 74, 48, 56};
        end else begin
            g = '{34, 56, 6, 3, 1, 25, 49, 6, 30, 18, 28, 38,
                  14, 18, 4, 16, 34, 22, 28};
        end
        return g;
    endfunction

    // Lit segments of a decimal digit, bit 0 = top bar, bit 6 = middle bar
    function automatic logic [6:0] segment_lamps(input logic [3:0] d);
        logic [6:0] m;
        case (d)
            4'd0:    m = 7'h3F;
            4'd1:    m = 7'h06;
            4'd2:    m = 7'h5B;
            4'd3:    m = 7'h4F;
            4'd4:    m = 7'h66;
            4'd5:    m = 7'h6D;
            4'd6:    m = 7'h7D;
            4'd7:    m = 7'h07;
            4'd8:    m = 7'h7F;
            default: m = 7'h6F;
        endcase
        return m;
    endfunction

    // Horizontal hexagon: inset grows with distance from the center row
    function automatic bit hex_bar(input int px, input int py, input int x, input int y,
                                   input int len, input int th);
        int r;
        int c;
        int ins;
        r = py - y;
        c = px - x;
        if (r < 0 || r >= th) return 1'b0;
        ins = th / 2 - r;
        if (ins < 0) ins = -ins;
        return c >= ins && c <= len - ins - 1;
    endfunction

    // Vertical bar with pointed top and bottom
    function automatic bit taper_bar(input int px, input int py, input int x, input int y,
                                     input int th, input int len);
        int r;
        int c;
        int half;
        int ins;
        r = py - y;
        c = px - x;
        half = th / 2;
        if (r < 0 || r >= len) return 1'b0;
        if (r >= len - half) begin
            ins = r - (len - half) + 1;
        end else begin
            ins = half - r;
            if (ins < 0) ins = 0;
        end
        return c >= ins && c < th - ins;
    endfunction

    // Work out all result fields of one pixel
    function automatic t_pixel_res render_pixel(input logic [7:0] code, input logic [6:0] xin,
                                                input logic [6:0] yin, input logic sel);
        t_font_geom g;
        t_pixel_res res;
        logic [6:0] m;
        int px;
        int py;
        int bw;
        int bh;
        int iw;
        bit lit;
        g   = font_geometry(sel);
        px  = xin;
        py  = yin;
        bw  = 0;
        bh  = 0;
        lit = 1'b0;
        res = '0;
        res.known = 1'b1;
        if (code == ssg_pkg::CHAR_SPACE) begin
            res.adv = 7'(g.dig_adv);
        end else if (code == ssg_pkg::CHAR_DASH) begin
            res.adv = 7'(g.dash_adv);
            bw = g.dash_w;
            bh = g.h;
        end else if (code == ssg_pkg::CHAR_COLON) begin
            res.adv = 7'(g.col_adv);
            bw = g.col_w;
            bh = g.h;
        end else if (code >= ssg_pkg::CHAR_ZERO && code <= ssg_pkg::CHAR_NINE) begin
            res.adv = 7'(g.dig_adv);
            bw = g.w;
            bh = g.h;
        end else begin
            res.known = 1'b0;
        end
        if (px < bw && py < bh) begin
            res.in_box = 1'b1;
            if (code == ssg_pkg::CHAR_DASH) begin
                lit = hex_bar(px, py, 0, (g.h - g.t) / 2, g.dash_w, g.t);
            end else if (code == ssg_pkg::CHAR_COLON) begin
                lit = px >= g.dot_x && px < g.dot_x + g.t &&
                      ((py >= g.dot_top && py < g.dot_top + g.t) ||
                       (py >= g.dot_bot && py < g.dot_bot + g.t));
            end else begin
                m  = segment_lamps(4'(code - ssg_pkg::CHAR_ZERO));
                iw = g.w - 2 * g.mx;
                if (m[0]) lit |= hex_bar(px, py, g.mx, g.top, iw, g.t);
                if (m[1]) lit |= taper_bar(px, py, g.rx, g.up, g.t, g.vh);
                if (m[2]) lit |= taper_bar(px, py, g.rx, g.low, g.t, g.vh);
                if (m[3]) lit |= hex_bar(px, py, g.mx, g.bot, iw, g.t);
                if (m[4]) lit |= taper_bar(px, py, 0, g.low, g.t, g.vh);
                if (m[5]) lit |= taper_bar(px, py, 0, g.up, g.t, g.vh);
                if (m[6]) lit |= hex_bar(px, py, g.mx, g.mid, iw, g.t);
            end
        end
        res.bw    = 7'(bw);
        res.bh    = 7'(bh);
        res.alpha = lit ? ssg_pkg::ALPHA_ON : 8'h00;
        return res;
    endfunction

    // Random pixel: mostly known glyphs near the box, some anywhere
    function automatic t_pixel_req random_request(input logic sel);
        t_pixel_req req;
        t_font_geom g;
        int pick;
        g    = font_geometry(sel);
        pick = $urandom_range(99);
        if (pick < 60)      req.code = ssg_pkg::CHAR_ZERO + 8'($urandom_range(9));
        else if (pick < 68) req.code = ssg_pkg::CHAR_DASH;
        else if (pick < 76) req.code = ssg_pkg::CHAR_COLON;
        else if (pick < 82) req.code = ssg_pkg::CHAR_SPACE;
        else                req.code = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) begin
            req.x = 7'($urandom_range(127));
            req.y = 7'($urandom_range(127));
        end else begin
            req.x = 7'($urandom_range(g.w + 1));
            req.y = 7'($urandom_range(g.h + 1));
        end
        return req;
    endfunction

    task automatic queue_pixel(input logic [7:0] code, input int x, input int y);
        t_pixel_req req;
        req.code = code;
        req.x    = 7'(x);
        req.y    = 7'(y);
        pixel_requests_q.push_back(req);
    endtask

    task automatic queue_random(input int count);
        repeat (count) pixel_requests_q.push_back(random_request(font_sel));
    endtask

    // Wait until every queued pixel has been sent and every result has come
    task automatic drain;
        while (pixel_requests_q.size() != 0 || i_valid || pixel_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access until pready
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_FONT_SEL) font_sel = data[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drive the input channel and the result stall
    always @(negedge clk) begin : drive_inputs
        t_pixel_req next_req;
        if (!rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || req_taken) begin
                if (hold_sender || pixel_requests_q.size() == 0 ||
                    $urandom_range(99) < idle_pct) begin
                    i_valid <= 1'b0;
                end else begin
                    next_req = pixel_requests_q.pop_front();
                    i_glyph_code <= next_req.code;
                    i_pixel_x    <= next_req.x;
                    i_pixel_y    <= next_req.y;
                    i_valid      <= 1'b1;
                end
            end
            i_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Predict on each input transfer, compare on each result transfer
    always @(posedge clk) begin : watch_outputs
        t_pixel_res want;
        if (!rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall)
                pixel_results_q.push_back(render_pixel(i_glyph_code, i_pixel_x, i_pixel_y,
                                                       font_sel));
            if (o_valid && !i_stall) begin
                if (pixel_results_q.size() == 0) begin
                    $error("result transfer with no pixel outstanding");
                    mismatch_count++;
                end else begin
                    want = pixel_results_q.pop_front();
                    pixels_checked++;
                    if (want.alpha == ssg_pkg::ALPHA_ON) pixels_lit++;
                    if (!want.known) unknown_seen++;
                    if (o_glyph_known !== want.known) begin
                        $error("glyph_known: expected %0d, got %0d", want.known, o_glyph_known);
                        mismatch_count++;
                    end
                    if (o_pixel_alpha !== want.alpha) begin
                        $error("pixel_alpha: expected %0d, got %0d", want.alpha, o_pixel_alpha);
                        mismatch_count++;
                    end
                    if (o_advance_width !== want.adv) begin
                        $error("advance_width: expected %0d, got %0d", want.adv,
                               o_advance_width);
                        mismatch_count++;
                    end
                    if (o_box_width !== want.bw) begin
                        $error("box_width: expected %0d, got %0d", want.bw, o_box_width);
                        mismatch_count++;
                    end
                    if (o_box_height !== want.bh) begin
                        $error("box_height: expected %0d, got %0d", want.bh, o_box_height);
                        mismatch_count++;
                    end
                    if (o_inside_box !== want.in_box) begin
                        $error("inside_box: expected %0d, got %0d", want.in_box, o_inside_box);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Stimulus phases
    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every glyph, box corners, just outside, unknown neighbors
        queue_pixel(ssg_pkg::CHAR_ZERO, 38, 8);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd1, 70, 30);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd2, 38, 61);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd3, 38, 115);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd4, 5, 30);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd5, 5, 80);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd6, 69, 80);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd7, 6, 8);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd8, 75, 123);
        queue_pixel(ssg_pkg::CHAR_NINE, 0, 0);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd8, 76, 10);
        queue_pixel(ssg_pkg::CHAR_ZERO + 8'd8, 10, 124);
        queue_pixel(ssg_pkg::CHAR_SPACE, 0, 0);
        queue_pixel(ssg_pkg::CHAR_DASH, 24, 61);
        queue_pixel(ssg_pkg::CHAR_DASH, 47, 123);
        queue_pixel(ssg_pkg::CHAR_DASH, 48, 61);
        queue_pixel(ssg_pkg::CHAR_COLON, 10, 42);
        queue_pixel(ssg_pkg::CHAR_COLON, 10, 78);
        queue_pixel(ssg_pkg::CHAR_COLON, 25, 0);
        queue_pixel(ssg_pkg::CHAR_ZERO - 8'd1, 10, 10);
        queue_pixel(ssg_pkg::CHAR_COLON + 8'd1, 10, 42);
        queue_pixel(8'h00, 0, 0);
        queue_pixel(8'hFF, 127, 127);
        queue_pixel(ssg_pkg::CHAR_ZERO, 127, 0);

        // Large font, then hold the sender until the pipe empties
        queue_random(280);
        while (pixel_requests_q.size() > 150) @(posedge clk);
        hold_sender = 1'b1;
        while (i_valid || pixel_results_q.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        // Compact font
        apb_write(ADDR_FONT_SEL, 32'h0000_0001);
        queue_random(300);
        drain();

        // Write to an unmapped address: font must stay compact
        apb_write(ADDR_SPARE, 32'h0000_0000);
        queue_random(150);
        drain();

        // Upper bits set, bit 0 clear: back to large
        apb_write(ADDR_FONT_SEL, 32'hFFFF_FFFE);
        queue_random(250);
        drain();

        // Compact again, back to back with no idling
        idle_pct = 0;
        apb_write(ADDR_FONT_SEL, 32'h0000_0003);
        queue_random(170);
        drain();
        idle_pct = IDLE_PCT;

        $display("checked %0d pixels over both font sizes: %0d lit, %0d unknown codes",
                 pixels_checked, pixels_lit, unknown_seen);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("watchdog expired with %0d results outstanding", pixel_results_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
